@@ rtl/core/rlsd_pkg.sv @@
// Shared types, sizes and codes for the LSD radix sorter.
// No dependencies; every other file in rtl/core except rlsd_ram refers to it by scoped names.
package rlsd_pkg;

	localparam int CAPACITY   = 64;
	localparam int MAX_RADIX  = 10;
	localparam int DATA_W     = 32;
	localparam int RADIX_W    = 4;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int DIG_W      = $clog2(MAX_RADIX);
	localparam int RAD_W      = $clog2(MAX_RADIX + 1);
	localparam int ENTRY_W    = 2 * DATA_W;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_ROUNDS = DATA_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_ROUNDS);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_res;
		logic                     overflow;
	} out_t;

	typedef enum logic [3:0] {
		S_LOAD, S_INIT, S_CLR, S_CNT_RD, S_CNT_DAT, S_CNT_DIV, S_PFX,
		S_SC_RD, S_SC_WR, S_RQ, S_RQ_WAIT, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_CLR, OP_CNT_RD, OP_CNT_DIV, OP_CNT_WR,
		OP_PFX, OP_SC_RD, OP_SC_WR, OP_RQ_START, OP_RQ_END, OP_OUT_RD,
		OP_OUT_LD, OP_OUT_NEXT
	} op_t;

	typedef struct packed {
		logic range_zero;
		logic cnt_end;
		logic pfx_end;
		logic sc_end;
		logic div_done;
		logic quot_zero;
		logic out_end;
	} status_t;

endpackage

@@ rtl/core/radix_lsd_sorter_unit.sv @@
// Top level of the LSD radix sorter: controller plus datapath.
// Depends on rlsd_pkg, rlsd_ctrl, rlsd_dp (and through it rlsd_ram, rlsd_div).
//
//  channel | signals                           | moves
//  --------+-----------------------------------+-------------------------------
//  in      | in_valid  in_ready  in_data       | one value (+last) per request
//  out     | out_valid out_ready out_data      | one sorted value per request
//  cfg     | cfg_valid cfg_ready cfg_data      | radix write, ready while loading
//
// Loading never stalls a request. Sorting n stored values takes a setup step (S_INIT),
// then P = digits of (max - min) in the radix passes, each a count walk through the
// four-round divider, a prefix sum over the buckets and a scatter. Each result is then
// read, registered and held until taken. Nothing is accepted while sorting or emitting.
// Stores need no clearing after reset; the unit is ready at once.
module radix_lsd_sorter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rlsd_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rlsd_pkg::out_t               out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rlsd_pkg::RADIX_W-1:0] cfg_data
);

	rlsd_pkg::op_t     op;
	rlsd_pkg::status_t status;

	// radix must not move under a running sort
	assign cfg_ready = in_ready;

	rlsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	rlsd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.status   (status),
		.in_data  (in_data),
		.out_data (out_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data)
	);

endmodule

@@ rtl/core/rlsd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/rlsd_div.sv @@
// Iterative divider of a 32-bit word by the radix, eight quotient bits a cycle.
// Depends on rlsd_pkg.
module rlsd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rlsd_pkg::DATA_W-1:0]      dividend,
	input  logic [rlsd_pkg::RAD_W-1:0]       divisor,
	output logic                             done,
	output logic [rlsd_pkg::DATA_W-1:0]      quot,
	output logic [rlsd_pkg::RAD_W-1:0]       rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [rlsd_pkg::DIV_CNT_W-1:0] round_q;
	logic [rlsd_pkg::DATA_W-1:0]    quot_q;
	logic [rlsd_pkg::RAD_W-1:0]     rem_q;
	logic [rlsd_pkg::DATA_W-1:0]    quot_nx;
	logic [rlsd_pkg::RAD_W-1:0]     rem_nx;

	// restoring division, DIV_STEPS bits per round
	always_comb begin
		logic [rlsd_pkg::RAD_W:0] t;
		quot_nx = quot_q;
		rem_nx  = rem_q;
		for (int k = 0; k < rlsd_pkg::DIV_STEPS; k++) begin
			t = {rem_nx, quot_nx[rlsd_pkg::DATA_W-1]};
			if (t >= {1'b0, divisor}) begin
				rem_nx  = rlsd_pkg::RAD_W'(t - {1'b0, divisor});
				quot_nx = {quot_nx[rlsd_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_nx  = t[rlsd_pkg::RAD_W-1:0];
				quot_nx = {quot_nx[rlsd_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 1'b1;
				if (round_q == rlsd_pkg::DIV_CNT_W'(rlsd_pkg::DIV_ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= quot_nx;
			rem_q  <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

@@ rtl/core/rlsd_dp.sv @@
// Sorter datapath: element stores, digit store, bucket counters, min/max, divider.
// Depends on rlsd_pkg, rlsd_ram, rlsd_div.
module rlsd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlsd_pkg::op_t                 op,
	output rlsd_pkg::status_t             status,
	input  rlsd_pkg::in_t                 in_data,
	output rlsd_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [rlsd_pkg::RADIX_W-1:0]  cfg_data
);

	localparam int DW = rlsd_pkg::DATA_W;

	logic [rlsd_pkg::RADIX_W-1:0] radix_q;
	logic                         sel_q;
	logic                         first_q;
	logic                         drop_q;
	logic [rlsd_pkg::CNT_W-1:0]   cnt_q;
	logic [rlsd_pkg::CNT_W-1:0]   idx_q;
	logic [rlsd_pkg::DIG_W-1:0]   j_q;
	logic signed [DW-1:0]         min_q;
	logic signed [DW-1:0]         max_q;
	logic [DW-1:0]                rq_q;
	logic [DW-1:0]                val_q;
	logic [rlsd_pkg::CNT_W-1:0]   acc_q;
	logic [rlsd_pkg::CNT_W-1:0]   bkt_q [rlsd_pkg::MAX_RADIX];
	rlsd_pkg::out_t               out_q;

	logic [rlsd_pkg::RAD_W-1:0]   r_eff;
	logic [DW-1:0]                range;
	logic [rlsd_pkg::CNT_W-1:0]   cnt_m1;

	// store ports
	logic                         a_we, b_we;
	logic [rlsd_pkg::IDX_W-1:0]   a_waddr, b_waddr, rd_addr;
	logic [rlsd_pkg::ENTRY_W-1:0] a_wdata, b_wdata;
	logic [rlsd_pkg::ENTRY_W-1:0] rd0, rd1, rd_a;
	logic                         dig_we;
	logic [rlsd_pkg::DIG_W-1:0]   dig_rd;

	// divider
	logic                         div_start;
	logic [DW-1:0]                div_in;
	logic                         div_done;
	logic [DW-1:0]                div_quot;
	logic [rlsd_pkg::RAD_W-1:0]   div_rem;
	logic [rlsd_pkg::DIG_W-1:0]   rem_d;

	// bucket access
	logic [rlsd_pkg::DIG_W-1:0]   bidx;
	logic [rlsd_pkg::CNT_W-1:0]   bkt_rd;
	logic [rlsd_pkg::CNT_W-1:0]   bkt_dec;

	always_comb begin
		if (radix_q < rlsd_pkg::RADIX_W'(2)) begin
			r_eff = rlsd_pkg::RAD_W'(2);
		end else if (int'(radix_q) > rlsd_pkg::MAX_RADIX) begin
			r_eff = rlsd_pkg::RAD_W'(rlsd_pkg::MAX_RADIX);
		end else begin
			r_eff = rlsd_pkg::RAD_W'(radix_q);
		end
	end

	assign range  = $unsigned(max_q - min_q);
	assign cnt_m1 = cnt_q - 1'b1;
	assign rd_a   = sel_q ? rd1 : rd0;
	assign rem_d  = rlsd_pkg::DIG_W'(div_rem);

	always_comb begin
		unique case (op)
			rlsd_pkg::OP_PFX:   bidx = j_q;
			rlsd_pkg::OP_SC_WR: bidx = dig_rd;
			default:            bidx = rem_d;
		endcase
	end
	assign bkt_rd  = bkt_q[bidx];
	assign bkt_dec = bkt_rd - 1'b1;

	always_comb begin
		a_we    = 1'b0;
		a_waddr = idx_q[rlsd_pkg::IDX_W-1:0];
		a_wdata = {val_q, div_quot};
		if (op == rlsd_pkg::OP_LOAD) begin
			a_we    = (int'(cnt_q) < rlsd_pkg::CAPACITY);
			a_waddr = cnt_q[rlsd_pkg::IDX_W-1:0];
			a_wdata = {in_data.value, {DW{1'b0}}};
		end else if (op == rlsd_pkg::OP_CNT_WR) begin
			a_we = 1'b1;
		end
		b_we    = (op == rlsd_pkg::OP_SC_WR);
		b_waddr = bkt_dec[rlsd_pkg::IDX_W-1:0];
		b_wdata = rd_a;
		dig_we  = (op == rlsd_pkg::OP_CNT_WR);
		rd_addr = (op == rlsd_pkg::OP_SC_RD) ? cnt_m1[rlsd_pkg::IDX_W-1:0] & '0 |
		          idx_q[rlsd_pkg::IDX_W-1:0] - 1'b1 : idx_q[rlsd_pkg::IDX_W-1:0];
	end

	always_comb begin
		div_start = (op == rlsd_pkg::OP_CNT_DIV) || (op == rlsd_pkg::OP_RQ_START);
		if (op == rlsd_pkg::OP_RQ_START) begin
			div_in = rq_q;
		end else if (first_q) begin
			div_in = rd_a[2*DW-1:DW] - $unsigned(min_q);
		end else begin
			div_in = rd_a[DW-1:0];
		end
	end

	rlsd_ram #(.WIDTH(rlsd_pkg::ENTRY_W), .DEPTH(rlsd_pkg::CAPACITY)) u_mem0 (
		.clk   (clk),
		.we    ((a_we && !sel_q) || (b_we && sel_q)),
		.waddr (sel_q ? b_waddr : a_waddr),
		.wdata (sel_q ? b_wdata : a_wdata),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	rlsd_ram #(.WIDTH(rlsd_pkg::ENTRY_W), .DEPTH(rlsd_pkg::CAPACITY)) u_mem1 (
		.clk   (clk),
		.we    ((a_we && sel_q) || (b_we && !sel_q)),
		.waddr (sel_q ? a_waddr : b_waddr),
		.wdata (sel_q ? a_wdata : b_wdata),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	rlsd_ram #(.WIDTH(rlsd_pkg::DIG_W), .DEPTH(rlsd_pkg::CAPACITY)) u_digits (
		.clk   (clk),
		.we    (dig_we),
		.waddr (idx_q[rlsd_pkg::IDX_W-1:0]),
		.wdata (rem_d),
		.raddr (rd_addr),
		.rdata (dig_rd)
	);

	rlsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (r_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rlsd_pkg::RADIX_RESET;
			sel_q   <= 1'b0;
			first_q <= 1'b0;
			drop_q  <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			j_q     <= '0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_data;
			end
			case (op)
				rlsd_pkg::OP_LOAD: begin
					if (int'(cnt_q) < rlsd_pkg::CAPACITY) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
				end
				rlsd_pkg::OP_INIT: begin
					first_q <= 1'b1;
					idx_q   <= '0;
				end
				rlsd_pkg::OP_CLR: begin
					idx_q <= '0;
					j_q   <= '0;
				end
				rlsd_pkg::OP_CNT_WR: idx_q <= idx_q + 1'b1;
				rlsd_pkg::OP_PFX: begin
					j_q   <= j_q + 1'b1;
					idx_q <= cnt_q;
				end
				rlsd_pkg::OP_SC_WR: idx_q <= idx_q - 1'b1;
				rlsd_pkg::OP_RQ_END: begin
					sel_q   <= ~sel_q;
					first_q <= 1'b0;
					idx_q   <= '0;
				end
				rlsd_pkg::OP_OUT_NEXT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == cnt_m1) begin
						cnt_q  <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			rlsd_pkg::OP_LOAD: begin
				if (cnt_q == '0) begin
					min_q <= in_data.value;
					max_q <= in_data.value;
				end else if (int'(cnt_q) < rlsd_pkg::CAPACITY) begin
					if (in_data.value < min_q) min_q <= in_data.value;
					if (in_data.value > max_q) max_q <= in_data.value;
				end
			end
			rlsd_pkg::OP_INIT: rq_q <= range;
			rlsd_pkg::OP_CLR: begin
				acc_q <= '0;
				for (int b = 0; b < rlsd_pkg::MAX_RADIX; b++) begin
					bkt_q[b] <= '0;
				end
			end
			rlsd_pkg::OP_CNT_DIV: val_q <= rd_a[2*DW-1:DW];
			rlsd_pkg::OP_CNT_WR:  bkt_q[bidx] <= bkt_rd + 1'b1;
			rlsd_pkg::OP_PFX: begin
				bkt_q[bidx] <= acc_q + bkt_rd;
				acc_q       <= acc_q + bkt_rd;
			end
			rlsd_pkg::OP_SC_WR:  bkt_q[bidx] <= bkt_dec;
			rlsd_pkg::OP_RQ_END: rq_q <= div_quot;
			rlsd_pkg::OP_OUT_LD: begin
				out_q.sorted_value <= $signed(rd_a[2*DW-1:DW]);
				out_q.last_res     <= (idx_q == cnt_m1);
				out_q.overflow     <= drop_q;
			end
			default: ;
		endcase
	end

	assign out_data          = out_q;
	assign status.range_zero = (range == '0);
	assign status.cnt_end    = (idx_q == cnt_m1);
	assign status.pfx_end    = (rlsd_pkg::RAD_W'(j_q) == r_eff - 1'b1);
	assign status.sc_end     = (idx_q == rlsd_pkg::CNT_W'(1));
	assign status.div_done   = div_done;
	assign status.quot_zero  = (div_quot == '0);
	assign status.out_end    = (idx_q == cnt_m1);

endmodule

@@ rtl/core/rlsd_ctrl.sv @@
// Sorter controller: sequences load, counting passes and result delivery.
// Depends on rlsd_pkg.
module rlsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rlsd_pkg::status_t status,
	output rlsd_pkg::op_t     op
);

	rlsd_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlsd_pkg::S_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		op        = rlsd_pkg::OP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rlsd_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = rlsd_pkg::OP_LOAD;
					if (in_last) state_nx = rlsd_pkg::S_INIT;
				end
			end
			rlsd_pkg::S_INIT: begin
				op       = rlsd_pkg::OP_INIT;
				state_nx = status.range_zero ? rlsd_pkg::S_OUT_RD : rlsd_pkg::S_CLR;
			end
			rlsd_pkg::S_CLR: begin
				op       = rlsd_pkg::OP_CLR;
				state_nx = rlsd_pkg::S_CNT_RD;
			end
			rlsd_pkg::S_CNT_RD: begin
				op       = rlsd_pkg::OP_CNT_RD;
				state_nx = rlsd_pkg::S_CNT_DAT;
			end
			rlsd_pkg::S_CNT_DAT: begin
				op       = rlsd_pkg::OP_CNT_DIV;
				state_nx = rlsd_pkg::S_CNT_DIV;
			end
			rlsd_pkg::S_CNT_DIV: begin
				if (status.div_done) begin
					op       = rlsd_pkg::OP_CNT_WR;
					state_nx = status.cnt_end ? rlsd_pkg::S_PFX : rlsd_pkg::S_CNT_RD;
				end
			end
			rlsd_pkg::S_PFX: begin
				op = rlsd_pkg::OP_PFX;
				if (status.pfx_end) state_nx = rlsd_pkg::S_SC_RD;
			end
			rlsd_pkg::S_SC_RD: begin
				op       = rlsd_pkg::OP_SC_RD;
				state_nx = rlsd_pkg::S_SC_WR;
			end
			rlsd_pkg::S_SC_WR: begin
				op       = rlsd_pkg::OP_SC_WR;
				state_nx = status.sc_end ? rlsd_pkg::S_RQ : rlsd_pkg::S_SC_RD;
			end
			rlsd_pkg::S_RQ: begin
				op       = rlsd_pkg::OP_RQ_START;
				state_nx = rlsd_pkg::S_RQ_WAIT;
			end
			rlsd_pkg::S_RQ_WAIT: begin
				if (status.div_done) begin
					op       = rlsd_pkg::OP_RQ_END;
					state_nx = status.quot_zero ? rlsd_pkg::S_OUT_RD : rlsd_pkg::S_CLR;
				end
			end
			rlsd_pkg::S_OUT_RD: begin
				op       = rlsd_pkg::OP_OUT_RD;
				state_nx = rlsd_pkg::S_OUT_LD;
			end
			rlsd_pkg::S_OUT_LD: begin
				op       = rlsd_pkg::OP_OUT_LD;
				state_nx = rlsd_pkg::S_OUT_WAIT;
			end
			rlsd_pkg::S_OUT_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					op       = rlsd_pkg::OP_OUT_NEXT;
					state_nx = status.out_end ? rlsd_pkg::S_LOAD : rlsd_pkg::S_OUT_RD;
				end
			end
			default: state_nx = rlsd_pkg::S_LOAD;
		endcase
	end

endmodule

@@ rtl/core/rlsd_checker.sv @@
// Port-level checks for the LSD radix sorter, bound to the top level.
// Depends on rlsd_pkg and radix_lsd_sorter_unit.
module rlsd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input rlsd_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input rlsd_pkg::out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	a_end_of_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_res |=> !out_valid)
		else $error("result after final element");

	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last |=> in_ready)
		else $error("ready dropped mid-set");

	a_stop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last |=> !in_ready)
		else $error("ready held after final request");

endmodule

bind radix_lsd_sorter_unit rlsd_checker u_rlsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
